FILE: sv/i2cmts_pkg.sv
// Package for the I2C master transaction sequencer.
// Holds bus status codes, acknowledge actions, request kinds and error codes.
// No dependencies.
package i2cmts_pkg;

	// Request kinds carried in the operation field.
	localparam logic OP_START = 1'b0;
	localparam logic OP_EVENT = 1'b1;

	// Bus controller status codes, with the low three bits cleared.
	localparam logic [7:0] ST_START        = 8'h08;
	localparam logic [7:0] ST_RESTART      = 8'h10;
	localparam logic [7:0] ST_SLAW_ACK     = 8'h18;
	localparam logic [7:0] ST_SLAW_NACK    = 8'h20;
	localparam logic [7:0] ST_TX_DATA_ACK  = 8'h28;
	localparam logic [7:0] ST_TX_DATA_NACK = 8'h30;
	localparam logic [7:0] ST_ARB_LOST     = 8'h38;
	localparam logic [7:0] ST_SLAR_ACK     = 8'h40;
	localparam logic [7:0] ST_SLAR_NACK    = 8'h48;
	localparam logic [7:0] ST_RX_DATA_ACK  = 8'h50;
	localparam logic [7:0] ST_RX_DATA_NACK = 8'h58;
	localparam logic [7:0] ST_ARB_SLA_W    = 8'h68;
	localparam logic [7:0] ST_ARB_GEN_CALL = 8'h78;
	localparam logic [7:0] ST_ARB_SLA_R    = 8'hB0;

	// Address byte masks.
	localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
	localparam logic [7:0] ADDR_READ_BIT   = 8'h01;

	// Acknowledge control actions.
	localparam logic [1:0] ACK_LEAVE = 2'd0;
	localparam logic [1:0] ACK_SET   = 2'd1;
	localparam logic [1:0] ACK_CLEAR = 2'd2;

	// Error codes latched at the end of a failed transfer.
	localparam logic [3:0] ERR_NONE          = 4'd0;
	localparam logic [3:0] ERR_COUNT         = 4'd1;
	localparam logic [3:0] ERR_START_STATE   = 4'd2;
	localparam logic [3:0] ERR_TX_STATE      = 4'd4;
	localparam logic [3:0] ERR_SLAR_STATE    = 4'd5;
	localparam logic [3:0] ERR_RX_ACK_STATE  = 4'd6;
	localparam logic [3:0] ERR_RX_NACK_STATE = 4'd7;
	localparam logic [3:0] ERR_NACK          = 4'd8;
	localparam logic [3:0] ERR_ARB_LOST      = 4'd9;
	localparam logic [3:0] ERR_UNKNOWN       = 4'd10;

endpackage

FILE: sv/i2c_master_transaction_sequencer.sv
// Top level of the I2C master transaction sequencer.
// Depends on i2cmts_pkg for status codes, acknowledge actions and error codes.
//
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------
// request  | in_valid / in_stall   | operation .. tx_byte, one bus event each
// result   | out_valid / out_stall | load_data .. error_code, one per request
//
// Each request passes from acceptance into the input register, then through the
// decode logic into the result register.
// A new request is accepted every cycle while the result side keeps up; the
// transfer state is updated as a request moves into the result register.
// Reset clears the transfer state and both valid flags; a stalled result holds
// and the input register then holds one further request before in_stall rises.
module i2c_master_transaction_sequencer #(
	parameter int unsigned MAX_BYTES = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       operation,
	input  logic [7:0] slave_address,
	input  logic       two_byte_address,
	input  logic       direction,
	input  logic [15:0] sub_address,
	input  logic [9:0] byte_count,
	input  logic [7:0] status_code,
	input  logic [7:0] rx_byte,
	input  logic [7:0] tx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       load_data,
	output logic [7:0] data_byte,
	output logic       send_start,
	output logic       send_stop,
	output logic [1:0] ack_action,
	output logic       release_interrupt,
	output logic       rx_valid,
	output logic       tx_taken,
	output logic       done_res,
	output logic [3:0] error_code
);
	import i2cmts_pkg::*;

	localparam logic [16:0] MaxCount = 17'(MAX_BYTES);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SLA_WR,
		PH_SUB_HI,
		PH_SUB_LO,
		PH_RESTART,
		PH_SLA_RD,
		PH_RECEIVE,
		PH_SEND
	} phase_t;

	// Input register.
	logic        valid_s1;
	logic        operation_s1;
	logic [7:0]  slave_address_s1;
	logic        two_byte_address_s1;
	logic        direction_s1;
	logic [15:0] sub_address_s1;
	logic [9:0]  byte_count_s1;
	logic [7:0]  status_code_s1;
	logic [7:0]  tx_byte_s1;

	// Transfer state.
	phase_t      phase_q;
	logic [7:0]  slave_byte_q;
	logic        wide_address_q;
	logic        is_write_q;
	logic [15:0] target_address_q;
	logic [9:0]  remaining_q;
	logic [3:0]  error_latch_q;
	logic        finished_q;

	// Next state.
	phase_t      phase_nxt;
	logic [7:0]  slave_byte_nxt;
	logic        wide_address_nxt;
	logic        is_write_nxt;
	logic [15:0] target_address_nxt;
	logic [9:0]  remaining_nxt;
	logic [3:0]  error_latch_nxt;
	logic        finished_nxt;

	// Result fields before the result register.
	logic        load_res;
	logic [7:0]  data_res;
	logic        start_res;
	logic        stop_res;
	logic [1:0]  ack_res;
	logic        rel_res;
	logic        rxv_res;
	logic        txt_res;
	logic [3:0]  err;
	logic [7:0]  status_masked;

	// Result register.
	logic        valid_s2;
	logic        load_data_s2;
	logic [7:0]  data_byte_s2;
	logic        send_start_s2;
	logic        send_stop_s2;
	logic [1:0]  ack_action_s2;
	logic        release_interrupt_s2;
	logic        rx_valid_s2;
	logic        tx_taken_s2;
	logic        done_res_s2;
	logic [3:0]  error_code_s2;

	logic out_free;
	logic advance;
	logic in_take;

	// Pipeline flow control.
	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	assign status_masked = {status_code_s1[7:3], 3'b000};

	// Decode of one request against the transfer state.
	always_comb begin
		phase_nxt          = phase_q;
		slave_byte_nxt     = slave_byte_q;
		wide_address_nxt   = wide_address_q;
		is_write_nxt       = is_write_q;
		target_address_nxt = target_address_q;
		remaining_nxt      = remaining_q;
		error_latch_nxt    = error_latch_q;
		finished_nxt       = finished_q;
		load_res  = 1'b0;
		data_res  = 8'h00;
		start_res = 1'b0;
		stop_res  = 1'b0;
		ack_res   = ACK_LEAVE;
		rel_res   = 1'b0;
		rxv_res   = 1'b0;
		txt_res   = 1'b0;
		err       = ERR_NONE;

		if (operation_s1 == OP_START) begin
			slave_byte_nxt     = slave_address_s1;
			wide_address_nxt   = two_byte_address_s1;
			is_write_nxt       = direction_s1;
			target_address_nxt = sub_address_s1;
			remaining_nxt      = byte_count_s1;
			error_latch_nxt    = ERR_NONE;
			finished_nxt       = 1'b0;
			if (byte_count_s1 == 10'd0 || {7'd0, byte_count_s1} > MaxCount) begin
				error_latch_nxt = ERR_COUNT;
				phase_nxt       = PH_IDLE;
				finished_nxt    = 1'b1;
			end else begin
				phase_nxt = PH_SLA_WR;
				start_res = 1'b1;
			end
		end else if (phase_q != PH_IDLE) begin
			unique case (status_masked)
				ST_START, ST_RESTART: begin
					if (phase_q == PH_SLA_WR) begin
						load_res  = 1'b1;
						data_res  = slave_byte_q & ADDR_WRITE_MASK;
						rel_res   = 1'b1;
						phase_nxt = wide_address_q ? PH_SUB_HI : PH_SUB_LO;
					end else if (phase_q == PH_SLA_RD) begin
						load_res  = 1'b1;
						data_res  = slave_byte_q | ADDR_READ_BIT;
						rel_res   = 1'b1;
						phase_nxt = PH_RECEIVE;
					end else begin
						err = ERR_START_STATE;
					end
				end
				ST_SLAW_ACK, ST_TX_DATA_ACK: begin
					if (phase_q == PH_SUB_HI) begin
						load_res  = 1'b1;
						data_res  = target_address_q[15:8];
						rel_res   = 1'b1;
						phase_nxt = PH_SUB_LO;
					end else if (phase_q == PH_SUB_LO) begin
						load_res  = 1'b1;
						data_res  = target_address_q[7:0];
						rel_res   = 1'b1;
						phase_nxt = is_write_q ? PH_SEND : PH_RESTART;
					end else if (phase_q == PH_RESTART) begin
						start_res = 1'b1;
						rel_res   = 1'b1;
						phase_nxt = PH_SLA_RD;
					end else if (phase_q == PH_SEND) begin
						if (remaining_q != 10'd0) begin
							load_res      = 1'b1;
							data_res      = tx_byte_s1;
							txt_res       = 1'b1;
							rel_res       = 1'b1;
							remaining_nxt = remaining_q - 10'd1;
						end else begin
							stop_res     = 1'b1;
							rel_res      = 1'b1;
							phase_nxt    = PH_IDLE;
							finished_nxt = 1'b1;
						end
					end else begin
						err = ERR_TX_STATE;
					end
				end
				ST_SLAR_ACK: begin
					if (phase_q == PH_RECEIVE) begin
						ack_res = (remaining_q <= 10'd1) ? ACK_CLEAR : ACK_SET;
						rel_res = 1'b1;
					end else begin
						err = ERR_SLAR_STATE;
					end
				end
				ST_RX_DATA_ACK: begin
					if (phase_q == PH_RECEIVE) begin
						if (remaining_q != 10'd0) begin
							rxv_res       = 1'b1;
							remaining_nxt = remaining_q - 10'd1;
							// The byte after this one is the last, so it gets a NACK.
							ack_res       = (remaining_q == 10'd2) ? ACK_CLEAR : ACK_SET;
							rel_res       = 1'b1;
						end else begin
							err = ERR_COUNT;
						end
					end else begin
						err = ERR_RX_ACK_STATE;
					end
				end
				ST_RX_DATA_NACK: begin
					if (phase_q == PH_RECEIVE) begin
						if (remaining_q == 10'd1) begin
							remaining_nxt = 10'd0;
							rxv_res       = 1'b1;
							stop_res      = 1'b1;
							rel_res       = 1'b1;
							phase_nxt     = PH_IDLE;
							finished_nxt  = 1'b1;
						end else begin
							err = ERR_COUNT;
						end
					end else begin
						err = ERR_RX_NACK_STATE;
					end
				end
				ST_SLAW_NACK, ST_TX_DATA_NACK, ST_SLAR_NACK: begin
					err = ERR_NACK;
				end
				ST_ARB_LOST, ST_ARB_SLA_W, ST_ARB_GEN_CALL, ST_ARB_SLA_R: begin
					err = ERR_ARB_LOST;
				end
				default: begin
					err = ERR_UNKNOWN;
				end
			endcase

			// Any error sends STOP and closes the transfer.
			if (err != ERR_NONE) begin
				load_res        = 1'b0;
				data_res        = 8'h00;
				start_res       = 1'b0;
				ack_res         = ACK_LEAVE;
				rxv_res         = 1'b0;
				txt_res         = 1'b0;
				stop_res        = 1'b1;
				rel_res         = 1'b1;
				error_latch_nxt = err;
				phase_nxt       = PH_IDLE;
				finished_nxt    = 1'b1;
			end
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			operation_s1        <= operation;
			slave_address_s1    <= slave_address;
			two_byte_address_s1 <= two_byte_address;
			direction_s1        <= direction;
			sub_address_s1      <= sub_address;
			byte_count_s1       <= byte_count;
			status_code_s1      <= status_code;
			tx_byte_s1          <= tx_byte;
		end
	end

	// Transfer state, updated as each request is decoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			slave_byte_q     <= 8'h00;
			wide_address_q   <= 1'b0;
			is_write_q       <= 1'b0;
			target_address_q <= 16'h0000;
			remaining_q      <= 10'd0;
			error_latch_q    <= ERR_NONE;
			finished_q       <= 1'b0;
		end else if (advance) begin
			phase_q          <= phase_nxt;
			slave_byte_q     <= slave_byte_nxt;
			wide_address_q   <= wide_address_nxt;
			is_write_q       <= is_write_nxt;
			target_address_q <= target_address_nxt;
			remaining_q      <= remaining_nxt;
			error_latch_q    <= error_latch_nxt;
			finished_q       <= finished_nxt;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			load_data_s2         <= load_res;
			data_byte_s2         <= data_res;
			send_start_s2        <= start_res;
			send_stop_s2         <= stop_res;
			ack_action_s2        <= ack_res;
			release_interrupt_s2 <= rel_res;
			rx_valid_s2          <= rxv_res;
			tx_taken_s2          <= txt_res;
			done_res_s2          <= finished_nxt;
			error_code_s2        <= error_latch_nxt;
		end
	end

	assign out_valid         = valid_s2;
	assign load_data         = load_data_s2;
	assign data_byte         = data_byte_s2;
	assign send_start        = send_start_s2;
	assign send_stop         = send_stop_s2;
	assign ack_action        = ack_action_s2;
	assign release_interrupt = release_interrupt_s2;
	assign rx_valid          = rx_valid_s2;
	assign tx_taken          = tx_taken_s2;
	assign done_res          = done_res_s2;
	assign error_code        = error_code_s2;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the I2C master transaction sequencer.
// Needs i2cmts_pkg and i2c_master_transaction_sequencer; a scoreboard class predicts each
// command set from the requests accepted, and plain tasks drive well-formed and broken transfers.
module tb;
	import i2cmts_pkg::*;

	localparam int unsigned TRANSFER_MAX = 512;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned TARGET_REQUESTS = 1700;

	// One request as presented on the input channel.
	typedef struct packed {
		logic        op;
		logic [7:0]  sla;
		logic        wide;
		logic        dir;
		logic [15:0] sub;
		logic [9:0]  count;
		logic [7:0]  status;
		logic [7:0]  rx;
		logic [7:0]  tx;
	} request_t;

	// One command set as returned on the result channel.
	typedef struct packed {
		logic       load;
		logic [7:0] data;
		logic       start;
		logic       stop;
		logic [1:0] ack;
		logic       rel;
		logic       rxv;
		logic       txt;
		logic       done;
		logic [3:0] err;
	} command_t;

	// Where the transfer stands between two bus events.
	typedef enum logic [2:0] {
		PH_IDLE, PH_SLA_WR, PH_SUB_HI, PH_SUB_LO, PH_RESTART, PH_SLA_RD, PH_RECEIVE, PH_SEND
	} seq_phase_t;

	class command_scoreboard;
		seq_phase_t  phase;
		logic [7:0]  slave_byte;
		logic        wide_address;
		logic        is_write;
		logic [15:0] target;
		logic [9:0]  remaining;
		logic [3:0]  error_latch;
		logic        finished;
		command_t    expected_commands[$];
		int unsigned mismatches;
		int unsigned results_seen;

		function new();
			phase = PH_IDLE;
			slave_byte = '0;
			wide_address = 1'b0;
			is_write = 1'b0;
			target = '0;
			remaining = '0;
			error_latch = ERR_NONE;
			finished = 1'b0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		task report(string what);
			$display("ERROR: %s", what);
			mismatches++;
		endtask

		function void end_transfer();
			phase = PH_IDLE;
			finished = 1'b1;
		endfunction

		// Works out the command set for an accepted request and queues it.
		// Returns 0 when the request was a bus event with no transfer running.
		function bit note_request(request_t r);
			command_t   c;
			logic [3:0] err;
			bit         acted;
			c = '0;
			err = ERR_NONE;
			acted = 1'b1;
			if (r.op == OP_START) begin
				slave_byte = r.sla;
				wide_address = r.wide;
				is_write = r.dir;
				target = r.sub;
				remaining = r.count;
				error_latch = ERR_NONE;
				finished = 1'b0;
				if (r.count == 0 || r.count > TRANSFER_MAX) begin
					error_latch = ERR_COUNT;
					end_transfer();
				end else begin
					phase = PH_SLA_WR;
					c.start = 1'b1;
				end
			end else if (phase == PH_IDLE) begin
				acted = 1'b0;
			end else begin
				case (r.status & 8'hF8)
					ST_START, ST_RESTART: begin
						if (phase == PH_SLA_WR) begin
							c.load = 1'b1;
							c.data = slave_byte & ADDR_WRITE_MASK;
							c.rel = 1'b1;
							phase = wide_address ? PH_SUB_HI : PH_SUB_LO;
						end else if (phase == PH_SLA_RD) begin
							c.load = 1'b1;
							c.data = slave_byte | ADDR_READ_BIT;
							c.rel = 1'b1;
							phase = PH_RECEIVE;
						end else begin
							err = ERR_START_STATE;
						end
					end
					ST_SLAW_ACK, ST_TX_DATA_ACK: begin
						if (phase == PH_SUB_HI) begin
							c.load = 1'b1;
							c.data = target[15:8];
							c.rel = 1'b1;
							phase = PH_SUB_LO;
						end else if (phase == PH_SUB_LO) begin
							c.load = 1'b1;
							c.data = target[7:0];
							c.rel = 1'b1;
							phase = is_write ? PH_SEND : PH_RESTART;
						end else if (phase == PH_RESTART) begin
							c.start = 1'b1;
							c.rel = 1'b1;
							phase = PH_SLA_RD;
						end else if (phase == PH_SEND) begin
							if (remaining != 0) begin
								c.load = 1'b1;
								c.data = r.tx;
								c.txt = 1'b1;
								c.rel = 1'b1;
								remaining--;
							end else begin
								c.stop = 1'b1;
								c.rel = 1'b1;
								end_transfer();
							end
						end else begin
							err = ERR_TX_STATE;
						end
					end
					ST_SLAR_ACK: begin
						if (phase == PH_RECEIVE) begin
							c.ack = (remaining <= 1) ? ACK_CLEAR : ACK_SET;
							c.rel = 1'b1;
						end else begin
							err = ERR_SLAR_STATE;
						end
					end
					ST_RX_DATA_ACK: begin
						if (phase != PH_RECEIVE) begin
							err = ERR_RX_ACK_STATE;
						end else if (remaining == 0) begin
							err = ERR_COUNT;
						end else begin
							c.rxv = 1'b1;
							remaining--;
							c.ack = (remaining == 1) ? ACK_CLEAR : ACK_SET;
							c.rel = 1'b1;
						end
					end
					ST_RX_DATA_NACK: begin
						if (phase != PH_RECEIVE) begin
							err = ERR_RX_NACK_STATE;
						end else if (remaining != 1) begin
							err = ERR_COUNT;
						end else begin
							remaining = '0;
							c.rxv = 1'b1;
							c.stop = 1'b1;
							c.rel = 1'b1;
							end_transfer();
						end
					end
					ST_SLAW_NACK, ST_TX_DATA_NACK, ST_SLAR_NACK: err = ERR_NACK;
					ST_ARB_LOST, ST_ARB_SLA_W, ST_ARB_GEN_CALL, ST_ARB_SLA_R: err = ERR_ARB_LOST;
					default: err = ERR_UNKNOWN;
				endcase
				// Any failure replaces the command set with a plain STOP.
				if (err != ERR_NONE) begin
					c = '0;
					c.stop = 1'b1;
					c.rel = 1'b1;
					error_latch = err;
					end_transfer();
				end
			end
			c.done = finished;
			c.err = error_latch;
			expected_commands.push_back(c);
			return acted;
		endfunction

		task check_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("result %0d: %s is %h, expected %h", results_seen, name, got, want));
		endtask

		// Compares a result with the oldest command set still waiting.
		task check_result(command_t got);
			command_t want;
			if (expected_commands.size() == 0) begin
				report($sformatf("result %0d arrived with no request waiting", results_seen));
			end else begin
				want = expected_commands.pop_front();
				check_field("load_data", 8'(got.load), 8'(want.load));
				check_field("data_byte", got.data, want.data);
				check_field("send_start", 8'(got.start), 8'(want.start));
				check_field("send_stop", 8'(got.stop), 8'(want.stop));
				check_field("ack_action", 8'(got.ack), 8'(want.ack));
				check_field("release_interrupt", 8'(got.rel), 8'(want.rel));
				check_field("rx_valid", 8'(got.rxv), 8'(want.rxv));
				check_field("tx_taken", 8'(got.txt), 8'(want.txt));
				check_field("done_res", 8'(got.done), 8'(want.done));
				check_field("error_code", 8'(got.err), 8'(want.err));
			end
			results_seen++;
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = 1'b0;
	logic [7:0]  slave_address = '0;
	logic        two_byte_address = 1'b0;
	logic        direction = 1'b0;
	logic [15:0] sub_address = '0;
	logic [9:0]  byte_count = '0;
	logic [7:0]  status_code = '0;
	logic [7:0]  rx_byte = '0;
	logic [7:0]  tx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        load_data;
	logic [7:0]  data_byte;
	logic        send_start;
	logic        send_stop;
	logic [1:0]  ack_action;
	logic        release_interrupt;
	logic        rx_valid;
	logic        tx_taken;
	logic        done_res;
	logic [3:0]  error_code;

	command_scoreboard sb = new();
	int unsigned requests_sent = 0;
	int unsigned cycle_count = 0;
	bit          quiet = 1'b0;
	bit          drained_once = 1'b0;

	i2c_master_transaction_sequencer #(
		.MAX_BYTES(TRANSFER_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.slave_address(slave_address),
		.two_byte_address(two_byte_address),
		.direction(direction),
		.sub_address(sub_address),
		.byte_count(byte_count),
		.status_code(status_code),
		.rx_byte(rx_byte),
		.tx_byte(tx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.load_data(load_data),
		.data_byte(data_byte),
		.send_start(send_start),
		.send_stop(send_stop),
		.ack_action(ack_action),
		.release_interrupt(release_interrupt),
		.rx_valid(rx_valid),
		.tx_taken(tx_taken),
		.done_res(done_res),
		.error_code(error_code)
	);

	// Clock generation.
	initial begin
		forever #2 clk = ~clk;
	end

	// Watchdog: a run that hangs ends here as a failure.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: check every accepted result and stall now and then.
	always @(posedge clk) begin
		command_t seen;
		seen = {load_data, data_byte, send_start, send_stop, ack_action,
			release_interrupt, rx_valid, tx_taken, done_res, error_code};
		if (arst_n && out_valid && !out_stall)
			sb.check_result(seen);
		out_stall <= !quiet && ($urandom_range(99) < 7);
	end

	// Every field random; callers then fix what matters.
	function automatic request_t noise_request();
		request_t r;
		r.op = 1'($urandom_range(1));
		r.sla = 8'($urandom_range(255));
		r.wide = 1'($urandom_range(1));
		r.dir = 1'($urandom_range(1));
		r.sub = 16'($urandom_range(65535));
		r.count = 10'($urandom_range(1023));
		r.status = 8'($urandom_range(255));
		r.rx = 8'($urandom_range(255));
		r.tx = 8'($urandom_range(255));
		return r;
	endfunction

	// Presents one request, with random gaps ahead of it, and waits until it is taken.
	task automatic send_request(input request_t r);
		while (!quiet && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= r.op;
		slave_address <= r.sla;
		two_byte_address <= r.wide;
		direction <= r.dir;
		sub_address <= r.sub;
		byte_count <= r.count;
		status_code <= r.status;
		rx_byte <= r.rx;
		tx_byte <= r.tx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (sb.note_request(r))
			requests_sent++;
	endtask

	task automatic start_transfer(input logic [7:0] sla, input logic wide, input logic dir,
			input logic [15:0] sub, input logic [9:0] count);
		request_t r;
		r = noise_request();
		r.op = OP_START;
		r.sla = sla;
		r.wide = wide;
		r.dir = dir;
		r.sub = sub;
		r.count = count;
		send_request(r);
	endtask

	task automatic send_event(input logic [7:0] code, input logic [7:0] tx);
		request_t r;
		r = noise_request();
		r.op = OP_EVENT;
		r.status = code;
		r.tx = tx;
		send_request(r);
	endtask

	// One transfer as the bus would report it, with the odd corrupted or abandoned step.
	task automatic run_transfer();
		logic [7:0]  codes[$];
		logic [7:0]  code;
		int unsigned n;
		int unsigned roll;
		logic        wide;
		logic        dir;
		wide = 1'($urandom_range(1));
		dir = 1'($urandom_range(1));
		n = ($urandom_range(199) == 0) ? $urandom_range(TRANSFER_MAX, 9) : $urandom_range(8, 1);
		start_transfer(8'($urandom_range(255)), wide, dir, 16'($urandom_range(65535)), 10'(n));
		codes.push_back(ST_START);
		codes.push_back(ST_SLAW_ACK);
		if (wide)
			codes.push_back(ST_TX_DATA_ACK);
		if (dir) begin
			repeat (n + 1) codes.push_back(ST_TX_DATA_ACK);
		end else begin
			codes.push_back(ST_TX_DATA_ACK);
			codes.push_back(ST_RESTART);
			codes.push_back(ST_SLAR_ACK);
			repeat (n - 1) codes.push_back(ST_RX_DATA_ACK);
			codes.push_back(ST_RX_DATA_NACK);
		end
		foreach (codes[i]) begin
			roll = $urandom_range(99);
			if (roll == 0)
				return;
			code = (roll < 3) ? 8'($urandom_range(255)) : (codes[i] | 8'($urandom_range(7)));
			send_event(code, 8'($urandom_range(255)));
			if (roll < 3)
				return;
		end
	endtask

	// Holds the request side until every expected result is back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_commands.size() != 0)
			@(posedge clk);
	endtask

	// Stimulus and end of run.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Event with nothing running, then bad counts at start.
		send_event(ST_START, 8'h00);
		start_transfer(8'h5A, 1'b0, 1'b1, 16'h1234, 10'd0);
		send_event(ST_SLAW_ACK, 8'h00);
		start_transfer(8'hA5, 1'b1, 1'b0, 16'h8001, 10'd1023);
		// Start while busy abandons the longest write.
		start_transfer(8'hFF, 1'b1, 1'b1, 16'hFFFF, 10'd512);
		send_event(ST_START, 8'h00);
		// Complete write with two sub-address bytes and one data byte.
		start_transfer(8'hFF, 1'b1, 1'b1, 16'hFFFF, 10'd1);
		send_event(ST_START | 8'h07, 8'h00);
		send_event(ST_SLAW_ACK, 8'h00);
		send_event(ST_TX_DATA_ACK, 8'h00);
		send_event(ST_TX_DATA_ACK, 8'hFF);
		send_event(ST_TX_DATA_ACK, 8'h00);
		// Read of one byte, then a further data byte that overruns the count.
		start_transfer(8'h00, 1'b0, 1'b0, 16'h0000, 10'd1);
		send_event(ST_START, 8'hFF);
		send_event(ST_SLAW_ACK, 8'hFF);
		send_event(ST_TX_DATA_ACK, 8'hFF);
		send_event(ST_RESTART, 8'hFF);
		send_event(ST_SLAR_ACK, 8'hFF);
		send_event(ST_RX_DATA_ACK, 8'hFF);
		send_event(ST_RX_DATA_ACK, 8'hFF);
		// NACK, lost arbitration and an unknown status each end a transfer.
		start_transfer(8'h3C, 1'b1, 1'b0, 16'h00FF, 10'd2);
		send_event(ST_SLAW_NACK, 8'h00);
		start_transfer(8'hC3, 1'b0, 1'b1, 16'hFF00, 10'd3);
		send_event(ST_ARB_SLA_R, 8'h00);
		start_transfer(8'h81, 1'b0, 1'b0, 16'h5555, 10'd4);
		send_event(8'h00, 8'h00);

		// Random transfers with some noise in between.
		while (requests_sent < TARGET_REQUESTS) begin
			quiet = (requests_sent >= 700 && requests_sent < 1000);
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(4, 1)) send_request(noise_request());
			end else begin
				run_transfer();
			end
			if (!drained_once && requests_sent >= 850) begin
				wait_drained();
				drained_once = 1'b1;
			end
		end
		quiet = 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
